// ===== hdl/ell_pkg.sv =====
package ell_pkg;

    // token kinds
    localparam logic [5:0] K_TEXT    = 6'd0;
    localparam logic [5:0] K_EOF     = 6'd1;
    localparam logic [5:0] K_IDENT   = 6'd2;
    localparam logic [5:0] K_WHOLE   = 6'd3;
    localparam logic [5:0] K_NEG     = 6'd4;
    localparam logic [5:0] K_STRING  = 6'd5;
    localparam logic [5:0] K_CHAR    = 6'd6;
    localparam logic [5:0] K_ESC     = 6'd7;
    localparam logic [5:0] K_TRUE    = 6'd8;
    localparam logic [5:0] K_FALSE   = 6'd9;
    localparam logic [5:0] K_LPAREN  = 6'd10;
    localparam logic [5:0] K_RPAREN  = 6'd11;
    localparam logic [5:0] K_LBRACK  = 6'd12;
    localparam logic [5:0] K_RBRACK  = 6'd13;
    localparam logic [5:0] K_LBRACE  = 6'd14;
    localparam logic [5:0] K_RBRACE  = 6'd15;
    localparam logic [5:0] K_SQ      = 6'd16;
    localparam logic [5:0] K_DQ      = 6'd17;
    localparam logic [5:0] K_SEMI    = 6'd18;
    localparam logic [5:0] K_COMMA   = 6'd19;
    localparam logic [5:0] K_ASSIGN  = 6'd20;
    localparam logic [5:0] K_BEQ     = 6'd21;
    localparam logic [5:0] K_PLUS    = 6'd22;
    localparam logic [5:0] K_MINUS   = 6'd23;
    localparam logic [5:0] K_STAR    = 6'd24;
    localparam logic [5:0] K_DIV     = 6'd25;
    localparam logic [5:0] K_MOD     = 6'd26;
    localparam logic [5:0] K_CARET   = 6'd27;
    localparam logic [5:0] K_LT      = 6'd28;
    localparam logic [5:0] K_GT      = 6'd30;
    localparam logic [5:0] K_NE      = 6'd35;
    localparam logic [5:0] K_AND     = 6'd32;
    localparam logic [5:0] K_OR      = 6'd33;
    localparam logic [5:0] K_NOT     = 6'd34;
    localparam logic [5:0] K_UNKNOWN = 6'd36;
    localparam logic [5:0] K_ERROR   = 6'd37;
    localparam logic [5:0] K_NONE    = 6'd0;

    // keyword tracker codes
    localparam logic [3:0] KW_DEAD  = 4'd15;
    localparam logic [3:0] KW_TRUE  = 4'd4;
    localparam logic [3:0] KW_FALSE = 4'd9;

    localparam int POS_BITS = 16;

    // classified input beat, front to back
    typedef struct packed {
        logic       eoi;
        logic [7:0] ch;
    } ell_item_t;

    // one result beat
    typedef struct packed {
        logic [5:0]  kind;
        logic [15:0] line;
        logic [15:0] col;
        logic [7:0]  text;
        logic        last;
    } ell_res_t;

    function automatic logic [15:0] cap16(input logic [32:0] v);
        cap16 = (v > 33'hFFFF) ? 16'hFFFF : v[15:0];
    endfunction

    function automatic logic is_space(input logic [7:0] c);
        is_space = (c == 8'd32) || (c >= 8'd9 && c <= 8'd13);
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        is_digit = c >= "0" && c <= "9";
    endfunction

    function automatic logic is_alpha(input logic [7:0] c);
        is_alpha = (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
    endfunction

    function automatic logic is_xdigit(input logic [7:0] c);
        is_xdigit = is_digit(c) || (c >= "a" && c <= "f") || (c >= "A" && c <= "F");
    endfunction

    function automatic logic [3:0] xval(input logic [7:0] c);
        logic [7:0] t;
        if (is_digit(c)) t = c - 8'd48;
        else if (c >= "a" && c <= "f") t = c - 8'd87;
        else t = c - 8'd55;
        xval = t[3:0];
    endfunction

    // keyword tracker over "TRUEFALSE"
    function automatic logic [3:0] kw_next(input logic [3:0] k, input logic [7:0] c);
        logic [7:0] w;
        case (k)
            4'd1:    w = "R";
            4'd2:    w = "U";
            4'd3:    w = "E";
            4'd5:    w = "A";
            4'd6:    w = "L";
            4'd7:    w = "S";
            4'd8:    w = "E";
            default: w = 8'd0;
        endcase
        if (k == 4'd0) kw_next = (c == "T") ? 4'd1 : ((c == "F") ? 4'd5 : KW_DEAD);
        else if (k == 4'd4 || k >= 4'd9) kw_next = KW_DEAD;
        else kw_next = (w == c) ? k + 4'd1 : KW_DEAD;
    endfunction

    function automatic logic neg_ok(input logic [5:0] p);
        neg_ok = p == K_NONE || p == K_LPAREN || p == K_ASSIGN || p == K_BEQ
              || (p >= K_PLUS && p <= 6'd31) || p == K_NE;
    endfunction

    function automatic logic [5:0] imm_kind(input logic [7:0] c);
        case (c)
            "(":     imm_kind = K_LPAREN;
            ")":     imm_kind = K_RPAREN;
            "[":     imm_kind = K_LBRACK;
            "]":     imm_kind = K_RBRACK;
            "{":     imm_kind = K_LBRACE;
            "}":     imm_kind = K_RBRACE;
            8'd39:   imm_kind = K_SQ;
            8'd34:   imm_kind = K_DQ;
            ";":     imm_kind = K_SEMI;
            ",":     imm_kind = K_COMMA;
            "+":     imm_kind = K_PLUS;
            "*":     imm_kind = K_STAR;
            "/":     imm_kind = K_DIV;
            "%":     imm_kind = K_MOD;
            "^":     imm_kind = K_CARET;
            default: imm_kind = K_NONE;
        endcase
    endfunction

endpackage

// ===== hdl/expression_language_lexer_core.sv =====
// Input beats wait in the front queue; their results wait in the result queue.
// Throughput: one input beat per cycle; each beat yields zero to three results,
// drained one per cycle through an eight-entry result queue.
// Input stalls (full) only when the result queue cannot take a worst-case burst.
// Reset (rst_n, async low) returns the scanner to idle at line 1, column 1,
// and empties both queues.
module expression_language_lexer_core
    import ell_pkg::*;
#(
    parameter int LINE_BITS   = 16,
    parameter int COLUMN_BITS = 16
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic [7:0]  char_byte,
    input  logic        end_of_input,
    input  logic        push,
    output logic        full,
    output logic [5:0]  kind,
    output logic [15:0] token_row,
    output logic [15:0] start_column,
    output logic [7:0]  text_byte,
    output logic        last,
    output logic        empty,
    input  logic        pop
);
    ell_item_t  item;
    logic       item_valid;
    logic       item_take;
    logic       room;
    logic       res_we;
    logic [1:0] res_n;
    ell_res_t   res0, res1, res2, head;

    ell_front u_front (
        .clk, .rst_n, .char_byte, .end_of_input, .push, .full,
        .item, .item_valid, .item_take
    );

    ell_scan #(.LINE_BITS(LINE_BITS), .COLUMN_BITS(COLUMN_BITS)) u_scan (
        .clk, .rst_n, .item, .item_valid, .item_take, .room,
        .res_we, .res_n, .res0, .res1, .res2
    );

    ell_outq u_outq (
        .clk, .rst_n, .we(res_we), .wn(res_n), .w0(res0), .w1(res1), .w2(res2),
        .room, .head, .empty, .pop
    );

    assign kind         = head.kind;
    assign token_row    = head.line;
    assign start_column = head.col;
    assign text_byte    = head.text;
    assign last         = head.last;
endmodule

// ===== hdl/ell_front.sv =====
// Two-entry item queue from the input to the scanner.
module ell_front
    import ell_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic [7:0] char_byte,
    input  logic      end_of_input,
    input  logic      push,
    output logic      full,
    output ell_item_t item,
    output logic      item_valid,
    input  logic      item_take
);
    ell_item_t q_reg [2];
    logic [1:0] cnt_reg;
    logic       rd_reg;
    logic       wr_reg;
    logic       do_push;

    assign full       = (cnt_reg == 2'd2);
    assign do_push    = push && !full;
    assign item_valid = (cnt_reg != 2'd0);
    assign item       = q_reg[rd_reg];

    // two-entry queue
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= 2'd0;
            rd_reg  <= 1'b0;
            wr_reg  <= 1'b0;
        end
        else
        begin
            if (do_push)
            begin
                wr_reg <= !wr_reg;
            end
            if (item_take && item_valid)
            begin
                rd_reg <= !rd_reg;
            end
            cnt_reg <= cnt_reg + {1'b0, do_push} - {1'b0, item_take && item_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            q_reg[wr_reg] <= '{eoi: end_of_input, ch: char_byte};
        end
    end

`ifndef SYNTHESIS
    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n) cnt_reg <= 2'd2)
        else $error("front count overflow");
    a_no_take_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (cnt_reg == 2'd0) |=> (cnt_reg <= 2'd1))
        else $error("front count jumped");
    a_full_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (full && !item_take) |=> full)
        else $error("front full dropped");
`endif
endmodule

// ===== hdl/ell_scan.sv =====
// Lexer state machine: one item per cycle while the result queue has room, up to three result beats.
module ell_scan
    import ell_pkg::*;
#(
    parameter int LINE_BITS   = 16,
    parameter int COLUMN_BITS = 16
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  ell_item_t item,
    input  logic      item_valid,
    output logic      item_take,
    input  logic      room,
    output logic      res_we,
    output logic [1:0] res_n,
    output ell_res_t  res0,
    output ell_res_t  res1,
    output ell_res_t  res2
);
    typedef enum logic [4:0] {
        M_IDLE, M_IDENT, M_NUM, M_NEG, M_MINUS, M_EQ, M_LT, M_GT, M_BANG,
        M_AMP, M_PIPE, M_STR, M_STR_ESC, M_STR_X, M_STR_H1, M_CHR_ESC,
        M_CHR_X, M_CHR_H1, M_DONE
    } mode_t;

    localparam logic [LINE_BITS-1:0]   LMAX = '1;
    localparam logic [COLUMN_BITS-1:0] CMAX = '1;

    mode_t                  mode_reg, mode_next;
    logic [LINE_BITS-1:0]   line_reg, line_next;
    logic [COLUMN_BITS-1:0] col_reg, col_next;
    logic [LINE_BITS-1:0]   tline_reg, tline_next;
    logic [COLUMN_BITS-1:0] tcol_reg, tcol_next;
    logic [5:0]             prev_reg, prev_next;
    logic                   smode_reg, smode_next;
    logic                   cmode_reg, cmode_next;
    logic [3:0]             kw_reg, kw_next_v;
    logic [7:0]             hex_reg, hex_next;
    logic                   err_reg, err_next;

    ell_res_t  r [3];
    logic [1:0] n;
    logic [7:0] c;
    logic [LINE_BITS-1:0]   nl;
    logic [COLUMN_BITS-1:0] ncol;
    logic [5:0] pk;
    logic [5:0] ik;
    logic [7:0] hx;
    logic       go;

    assign c         = item.ch;
    assign item_take = item_valid && room;
    assign go        = item_take && !err_reg && mode_reg != M_DONE;

    function automatic ell_res_t mk(input logic [5:0] k, input logic [LINE_BITS-1:0] l,
                                    input logic [COLUMN_BITS-1:0] cc, input logic [7:0] b);
        mk = '{kind: k, line: cap16(33'(l)), col: cap16(33'(cc)), text: b, last: 1'b0};
    endfunction

    always_comb
    begin
        mode_next  = mode_reg;
        line_next  = line_reg;
        col_next   = col_reg;
        tline_next = tline_reg;
        tcol_next  = tcol_reg;
        prev_next  = prev_reg;
        smode_next = smode_reg;
        cmode_next = cmode_reg;
        kw_next_v  = kw_reg;
        hex_next   = hex_reg;
        err_next   = err_reg;
        n  = 2'd0;
        r[0] = '0;
        r[1] = '0;
        r[2] = '0;
        nl = line_reg;
        ncol = col_reg;
        ik = K_NONE;
        hx = 8'd0;

        // pending-token kind
        case (mode_reg)
            M_IDENT: pk = (kw_reg == KW_TRUE) ? K_TRUE : ((kw_reg == KW_FALSE) ? K_FALSE : K_IDENT);
            M_NUM:   pk = K_WHOLE;
            M_NEG:   pk = K_NEG;
            M_MINUS: pk = K_MINUS;
            M_EQ:    pk = K_ASSIGN;
            M_LT:    pk = K_LT;
            M_GT:    pk = K_GT;
            default: pk = K_NOT;
        endcase

        if (go && item.eoi)
        begin
            if (smode_reg || mode_reg == M_AMP || mode_reg == M_PIPE
                || mode_reg == M_CHR_ESC || mode_reg == M_CHR_X)
            begin
                r[0] = mk(K_ERROR, line_reg, col_reg, 8'd0);
                n = 2'd1;
                err_next = 1'b1;
                mode_next = M_DONE;
            end
            else
            begin
                if (mode_reg inside {M_IDENT, M_NUM, M_NEG, M_MINUS, M_EQ, M_LT, M_GT, M_BANG})
                begin
                    r[0] = mk(pk, line_reg, tcol_reg, 8'd0);
                    n = 2'd1;
                end
                else if (mode_reg == M_CHR_H1)
                begin
                    r[0] = mk(K_TEXT, tline_reg, tcol_reg, hex_reg);
                    r[1] = mk(K_ESC, line_reg, tcol_reg, 8'd0);
                    n = 2'd2;
                end
                r[n] = mk(K_EOF, line_reg, col_reg, 8'd0);
                n = n + 2'd1;
                prev_next = K_EOF;
                mode_next = M_DONE;
            end
        end
        else if (go)
        begin
            // position counters
            if (col_reg != CMAX) col_next = col_reg + 1'b1;
            if (c == 8'd10)
            begin
                if (line_reg != LMAX) line_next = line_reg + 1'b1;
                col_next = COLUMN_BITS'(1);
            end
            nl = line_next;
            ncol = (c == 8'd10) ? '0 : col_reg;

            // fresh: start a token at c after optional close
            begin : scan_body
                logic do_fresh;
                logic close_first;
                logic [LINE_BITS-1:0] cl_line;
                do_fresh = 1'b0;
                close_first = 1'b0;
                cl_line = line_reg;
                case (mode_reg)
                    M_IDLE: do_fresh = 1'b1;
                    M_IDENT:
                        if (is_alpha(c) || is_digit(c) || c == "_")
                        begin
                            r[0] = mk(K_TEXT, tline_reg, tcol_reg, c);
                            n = 2'd1;
                            kw_next_v = kw_next(kw_reg, c);
                        end
                        else
                        begin
                            close_first = 1'b1;
                            do_fresh = 1'b1;
                        end
                    M_NUM, M_NEG:
                        if (is_digit(c))
                        begin
                            r[0] = mk(K_TEXT, tline_reg, tcol_reg, c);
                            n = 2'd1;
                        end
                        else
                        begin
                            close_first = 1'b1;
                            do_fresh = 1'b1;
                        end
                    M_MINUS:
                        if (is_space(c))
                        begin
                        end
                        else if (is_digit(c) && neg_ok(prev_reg))
                        begin
                            r[0] = mk(K_TEXT, tline_reg, tcol_reg, "-");
                            r[1] = mk(K_TEXT, tline_reg, tcol_reg, c);
                            n = 2'd2;
                            mode_next = M_NEG;
                        end
                        else
                        begin
                            close_first = 1'b1;
                            do_fresh = 1'b1;
                        end
                    M_EQ, M_LT, M_GT, M_BANG:
                        if (c == "=")
                        begin
                            r[0] = mk(pk + 6'd1, nl, tcol_reg, 8'd0);
                            n = 2'd1;
                            prev_next = pk + 6'd1;
                            mode_next = M_IDLE;
                        end
                        else
                        begin
                            close_first = 1'b1;
                            do_fresh = 1'b1;
                        end
                    M_AMP, M_PIPE:
                        if (c == ((mode_reg == M_AMP) ? "&" : "|"))
                        begin
                            r[0] = mk((mode_reg == M_AMP) ? K_AND : K_OR, nl, tcol_reg, 8'd0);
                            n = 2'd1;
                            prev_next = (mode_reg == M_AMP) ? K_AND : K_OR;
                            mode_next = M_IDLE;
                        end
                        else
                        begin
                            r[0] = mk(K_ERROR, line_reg, col_reg, c);
                            n = 2'd1;
                            err_next = 1'b1;
                            mode_next = M_DONE;
                        end
                    M_STR:
                    begin
                        if (c == 8'd34)
                        begin
                            r[0] = mk(K_STRING, tline_reg, tcol_reg, 8'd0);
                            r[1] = mk(K_DQ, nl, ncol, 8'd0);
                            n = 2'd2;
                            prev_next = K_DQ;
                            smode_next = 1'b0;
                            mode_next = M_IDLE;
                        end
                        else if (c == 8'd92) mode_next = M_STR_ESC;
                        else
                        begin
                            r[0] = mk(K_TEXT, tline_reg, tcol_reg, c);
                            n = 2'd1;
                        end
                    end
                    M_STR_ESC, M_CHR_ESC:
                    begin
                        case (c)
                            8'd92:   hx = 8'd92;
                            "n":     hx = 8'd10;
                            8'd39:   hx = 8'd39;
                            8'd34:   hx = 8'd34;
                            default: hx = 8'd0;
                        endcase
                        if (c == "x")
                            mode_next = (mode_reg == M_STR_ESC) ? M_STR_X : M_CHR_X;
                        else if (hx == 8'd0)
                        begin
                            r[0] = mk(K_ERROR, line_reg, col_reg, c);
                            n = 2'd1;
                            err_next = 1'b1;
                            mode_next = M_DONE;
                        end
                        else
                        begin
                            r[0] = mk(K_TEXT, tline_reg, tcol_reg, hx);
                            n = 2'd1;
                            if (mode_reg == M_STR_ESC) mode_next = M_STR;
                            else
                            begin
                                r[1] = mk(K_ESC, nl, tcol_reg, 8'd0);
                                n = 2'd2;
                                prev_next = K_ESC;
                                mode_next = M_IDLE;
                            end
                        end
                    end
                    M_STR_X, M_CHR_X:
                        if (!is_xdigit(c))
                        begin
                            r[0] = mk(K_ERROR, line_reg, col_reg, c);
                            n = 2'd1;
                            err_next = 1'b1;
                            mode_next = M_DONE;
                        end
                        else
                        begin
                            hex_next = {4'd0, xval(c)};
                            mode_next = (mode_reg == M_STR_X) ? M_STR_H1 : M_CHR_H1;
                        end
                    M_STR_H1:
                        if (is_xdigit(c))
                        begin
                            r[0] = mk(K_TEXT, tline_reg, tcol_reg, {hex_reg[3:0], xval(c)});
                            n = 2'd1;
                            mode_next = M_STR;
                        end
                        else
                        begin
                            r[0] = mk(K_TEXT, tline_reg, tcol_reg, hex_reg);
                            n = 2'd1;
                            mode_next = M_STR;
                            if (c == 8'd34)
                            begin
                                r[1] = mk(K_STRING, tline_reg, tcol_reg, 8'd0);
                                r[2] = mk(K_DQ, nl, ncol, 8'd0);
                                n = 2'd3;
                                prev_next = K_DQ;
                                smode_next = 1'b0;
                                mode_next = M_IDLE;
                            end
                            else if (c == 8'd92) mode_next = M_STR_ESC;
                            else
                            begin
                                r[1] = mk(K_TEXT, tline_reg, tcol_reg, c);
                                n = 2'd2;
                            end
                        end
                    M_CHR_H1:
                        if (is_xdigit(c))
                        begin
                            r[0] = mk(K_TEXT, tline_reg, tcol_reg, {hex_reg[3:0], xval(c)});
                            r[1] = mk(K_ESC, nl, tcol_reg, 8'd0);
                            n = 2'd2;
                            prev_next = K_ESC;
                            mode_next = M_IDLE;
                        end
                        else
                        begin
                            r[0] = mk(K_TEXT, tline_reg, tcol_reg, hex_reg);
                            r[1] = mk(K_ESC, line_reg, tcol_reg, 8'd0);
                            n = 2'd2;
                            prev_next = K_ESC;
                            do_fresh = 1'b1;
                        end
                    default: ;
                endcase

                if (close_first)
                begin
                    r[0] = mk(pk, cl_line, tcol_reg, 8'd0);
                    n = 2'd1;
                    prev_next = pk;
                end

                if (do_fresh)
                begin
                    tline_next = nl;
                    tcol_next = ncol;
                    mode_next = M_IDLE;
                    ik = imm_kind(c);
                    if (cmode_reg && prev_next == K_SQ)
                    begin
                        if (c == 8'd92) mode_next = M_CHR_ESC;
                        else
                        begin
                            r[n] = mk(K_TEXT, nl, ncol, c);
                            r[n + 2'd1] = mk(K_CHAR, nl, ncol, 8'd0);
                            n = n + 2'd2;
                            prev_next = K_CHAR;
                        end
                    end
                    else if (smode_reg && prev_next == K_DQ)
                    begin
                        mode_next = M_STR;
                        if (c == 8'd34)
                        begin
                            r[n] = mk(K_STRING, nl, ncol, 8'd0);
                            r[n + 2'd1] = mk(K_DQ, nl, ncol, 8'd0);
                            n = n + 2'd2;
                            prev_next = K_DQ;
                            smode_next = 1'b0;
                            mode_next = M_IDLE;
                        end
                        else if (c == 8'd92) mode_next = M_STR_ESC;
                        else
                        begin
                            r[n] = mk(K_TEXT, nl, ncol, c);
                            n = n + 2'd1;
                        end
                    end
                    else if (is_space(c))
                    begin
                        if (cmode_reg || smode_reg)
                        begin
                            r[n] = mk(K_UNKNOWN, nl, ncol, c);
                            n = n + 2'd1;
                            prev_next = K_NONE;
                        end
                    end
                    else if (is_alpha(c) || c == "_")
                    begin
                        r[n] = mk(K_TEXT, nl, ncol, c);
                        n = n + 2'd1;
                        kw_next_v = kw_next(4'd0, c);
                        mode_next = M_IDENT;
                    end
                    else if (is_digit(c))
                    begin
                        r[n] = mk(K_TEXT, nl, ncol, c);
                        n = n + 2'd1;
                        mode_next = M_NUM;
                    end
                    else if (ik != K_NONE)
                    begin
                        r[n] = mk(ik, nl, ncol, 8'd0);
                        n = n + 2'd1;
                        prev_next = ik;
                        if (ik == K_SQ) cmode_next = !cmode_reg;
                        if (ik == K_DQ) smode_next = !smode_reg;
                    end
                    else
                    begin
                        case (c)
                            "=": mode_next = M_EQ;
                            "<": mode_next = M_LT;
                            ">": mode_next = M_GT;
                            "!": mode_next = M_BANG;
                            "&": mode_next = M_AMP;
                            "|": mode_next = M_PIPE;
                            "-": mode_next = M_MINUS;
                            default:
                            begin
                                r[n] = mk(K_UNKNOWN, nl, ncol, c);
                                n = n + 2'd1;
                                prev_next = K_NONE;
                            end
                        endcase
                    end
                end
            end
        end

        // mark final beat
        if (n != 2'd0) r[n - 2'd1].last = 1'b1;
    end

    assign res_we = go && (n != 2'd0);
    assign res_n  = n;
    assign res0   = r[0];
    assign res1   = r[1];
    assign res2   = r[2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= M_IDLE;
            line_reg  <= LINE_BITS'(1);
            col_reg   <= COLUMN_BITS'(1);
            tline_reg <= LINE_BITS'(1);
            tcol_reg  <= '0;
            prev_reg  <= K_NONE;
            smode_reg <= 1'b0;
            cmode_reg <= 1'b0;
            kw_reg    <= 4'd0;
            hex_reg   <= 8'd0;
            err_reg   <= 1'b0;
        end
        else if (go)
        begin
            mode_reg  <= mode_next;
            line_reg  <= line_next;
            col_reg   <= col_next;
            tline_reg <= tline_next;
            tcol_reg  <= tcol_next;
            prev_reg  <= prev_next;
            smode_reg <= smode_next;
            cmode_reg <= cmode_next;
            kw_reg    <= kw_next_v;
            hex_reg   <= hex_next;
            err_reg   <= err_next;
        end
    end

`ifndef SYNTHESIS
    a_err_done: assert property (@(posedge clk) disable iff (!rst_n)
        err_reg |-> mode_reg == M_DONE)
        else $error("error without done");
    a_err_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        err_reg |=> err_reg)
        else $error("error cleared");
    a_done_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        (mode_reg == M_DONE) |-> !res_we)
        else $error("result after done");
    a_line_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        line_reg != '0)
        else $error("line counter zero");
`endif
endmodule

// ===== hdl/ell_outq.sv =====
// Result queue: takes up to three beats per cycle, gives one.
module ell_outq
    import ell_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      we,
    input  logic [1:0] wn,
    input  ell_res_t  w0,
    input  ell_res_t  w1,
    input  ell_res_t  w2,
    output logic      room,
    output ell_res_t  head,
    output logic      empty,
    input  logic      pop
);
    localparam int DEPTH = 8;
    ell_res_t   q_reg [DEPTH];
    logic [2:0] rd_reg;
    logic [2:0] wr_reg;
    logic [3:0] cnt_reg;
    logic       do_pop;
    logic [3:0] wadd;

    assign empty  = (cnt_reg == 4'd0);
    assign do_pop = pop && !empty;
    assign head   = q_reg[rd_reg];
    assign room   = (cnt_reg <= 4'd5);
    assign wadd   = we ? {2'd0, wn} : 4'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_reg  <= '0;
            wr_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wr_reg  <= wr_reg + wadd[2:0];
            rd_reg  <= rd_reg + {2'd0, do_pop};
            cnt_reg <= cnt_reg + wadd - {3'd0, do_pop};
        end
    end

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            q_reg[wr_reg] <= w0;
            if (wn >= 2'd2) q_reg[wr_reg + 3'd1] <= w1;
            if (wn == 2'd3) q_reg[wr_reg + 3'd2] <= w2;
        end
    end

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= 4'd8)
        else $error("result queue overflow");
    a_write_room: assert property (@(posedge clk) disable iff (!rst_n)
        we |-> (cnt_reg + {2'd0, wn}) <= 4'd8)
        else $error("write without room");
    a_empty_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (empty && !we) |=> empty)
        else $error("queue filled from nothing");
`endif
endmodule
